[design/assert_macros.svh]
// Assertion macros for the periodic ticker bank top level.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define PTB_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define PTB_IMPLY_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ptb_pkg.sv]
// Package for the periodic ticker bank: transaction payload types, slot state
// record and operation codes. No dependencies.
package ptb_pkg;

	localparam int SlotsDefault = 16;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ARM  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [3:0]         slot;
		logic [15:0]        first_delay;
		logic [15:0]        reload_period;
		logic signed [15:0] repeats;
		logic [7:0]         payload_tag;
	} item_t;

	typedef struct packed {
		logic [3:0] fired_slot;
		logic [7:0] fired_tag;
		logic       last;
	} fire_t;

	// One timer slot as it travels around the ring.
	typedef struct packed {
		logic        active;
		logic [15:0] delay;
		logic [15:0] period;
		logic [15:0] repeats;
		logic [7:0]  tag;
	} slot_t;

endpackage

[design/periodic_ticker_bank.sv]
// Top level of the periodic ticker bank: ring of ptb_cell with a ptb_fire head.
// Depends on ptb_pkg, ptb_cell, ptb_fire and assert_macros.svh.
//
// Usage:
//   Item channel (item_valid / item_stall / item): an arm transaction writes
//   one slot and gives no result; an arm of a slot at or above
//   SLOTS is dropped. A tick transaction walks the ring of SLOTS cells: on every
//   shift the record in cell 0 passes through the update head and re-enters at
//   the far end, so after SLOTS shifts every slot is back in its own cell.
//   Fire channel (fire_valid / fire_stall / fire): one transaction per firing
//   slot, in ascending slot order; last marks the final firing of a tick.
//   One firing is held back in a pending register until the next firing or the
//   end of the walk decides its last bit, and then moves to the output register.
//   A tick holds item_stall high for the whole walk and until the pending
//   firing is released. The ring shift is the rate limiter: one slot per
//   cycle, unless a new firing meets a pending one and a stalled full output.
//   When fire_stall holds a full output register and another firing shows up,
//   hold the ring in place until the output frees up.
//   Reset clears all active marks, the walk and both output stages.
`include "assert_macros.svh"

module periodic_ticker_bank #(
	parameter int SLOTS = ptb_pkg::SlotsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  ptb_pkg::item_t item,
	output logic           fire_valid,
	input  logic           fire_stall,
	output ptb_pkg::fire_t fire
);

	localparam int CW = $clog2(SLOTS + 1);

	ptb_pkg::slot_t cell_q [SLOTS];
	ptb_pkg::slot_t head_nxt;
	ptb_pkg::slot_t arm_d;
	logic           head_fire;
	logic [SLOTS-1:0] arm_sel;

	logic          walking_q;
	logic [CW-1:0] walk_q;
	logic          pend_valid_q;
	logic [3:0]    pend_slot_q;
	logic [7:0]    pend_tag_q;
	logic          out_valid_q;
	ptb_pkg::fire_t out_q;

	logic item_acc;
	logic tick_acc;
	logic arm_acc;
	logic out_free;
	logic shift;
	logic walk_end;
	logic finish;

	// Busy for the whole walk and until the pending firing is released.
	assign item_stall = walking_q || pend_valid_q;
	assign item_acc   = item_valid && !item_stall;
	assign tick_acc   = item_acc && (item.operation == ptb_pkg::OP_TICK);
	assign arm_acc    = item_acc && (item.operation == ptb_pkg::OP_ARM);

	assign out_free = !out_valid_q || !fire_stall;
	// Advance the ring unless a new firing would need a full output register.
	assign shift    = walking_q && !(head_fire && pend_valid_q && !out_free);
	assign walk_end = shift && (walk_q == CW'(SLOTS - 1));
	assign finish   = !walking_q && pend_valid_q && out_free;

	always_comb begin
		arm_d.active  = 1'b1;
		arm_d.delay   = item.first_delay;
		arm_d.period  = item.reload_period;
		arm_d.repeats = item.repeats;
		arm_d.tag     = item.payload_tag;
	end

	ptb_fire u_fire (
		.cur  (cell_q[0]),
		.nxt  (head_nxt),
		.fire (head_fire)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ptb_pkg::slot_t shift_d;

		assign arm_sel[i] = arm_acc && (int'(item.slot) == i);

		if (i == SLOTS - 1) begin : g_tail
			assign shift_d = head_nxt;
		end else begin : g_mid
			assign shift_d = cell_q[i+1];
		end

		ptb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.load    (arm_sel[i]),
			.shift_d (shift_d),
			.load_d  (arm_d),
			.q       (cell_q[i])
		);
	end

	// Walk control: the counter is also the slot number at the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
			walk_q    <= '0;
		end else if (tick_acc) begin
			walking_q <= 1'b1;
			walk_q    <= '0;
		end else if (shift) begin
			walk_q <= walk_q + CW'(1);
			if (walk_end) begin
				walking_q <= 1'b0;
			end
		end
	end

	// Pending firing: holds the latest firing until its last bit is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (shift && head_fire) begin
			pend_valid_q <= 1'b1;
		end else if (finish) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && head_fire) begin
			pend_slot_q <= 4'(walk_q);
			pend_tag_q  <= cell_q[0].tag;
		end
	end

	// Output register: a later firing pushes the pending one out as not last,
	// the end of the walk pushes it out as last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((shift && head_fire && pend_valid_q) || finish) begin
			out_valid_q <= 1'b1;
		end else if (!fire_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((shift && head_fire && pend_valid_q) || finish) begin
			out_q.fired_slot <= pend_slot_q;
			out_q.fired_tag  <= pend_tag_q;
			out_q.last       <= finish;
		end
	end

	assign fire_valid = out_valid_q;
	assign fire       = out_q;

	`PTB_IMPLY(a_walk_in_range, walking_q, walk_q < CW'(SLOTS), "walk counter past last slot")
	`PTB_IMPLY_NEXT(a_tick_starts_walk, tick_acc, walking_q && (walk_q == '0),
		"tick did not start a walk at slot zero")
	`PTB_IMPLY(a_no_overwrite, (shift && head_fire && pend_valid_q) || finish, out_free,
		"output register overwritten while stalled")
	`PTB_IMPLY_NEXT(a_finish_idle, finish, !item_stall, "block still busy after last firing")

endmodule

[design/ptb_cell.sv]
// One storage cell of the timer ring: holds a single slot record.
// Depends on ptb_pkg.
module ptb_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  logic           load,
	input  ptb_pkg::slot_t shift_d,
	input  ptb_pkg::slot_t load_d,
	output ptb_pkg::slot_t q
);

	logic active_q;
	ptb_pkg::slot_t data_q;

	// Active mark resets; the rest is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= load_d.active;
		end else if (shift) begin
			active_q <= shift_d.active;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_d;
		end else if (shift) begin
			data_q <= shift_d;
		end
	end

	always_comb begin
		q = data_q;
		q.active = active_q;
	end

endmodule

[design/ptb_fire.sv]
// Head update of the timer ring: advance, fire and reload one slot record.
// Depends on ptb_pkg.
module ptb_fire (
	input  ptb_pkg::slot_t cur,
	output ptb_pkg::slot_t nxt,
	output logic           fire
);

	always_comb begin
		nxt  = cur;
		fire = 1'b0;
		if (cur.active) begin
			if (cur.delay != 16'd0) begin
				nxt.delay = cur.delay - 16'd1;
			end else begin
				fire = 1'b1;
				if (cur.repeats == 16'd0) begin
					nxt.active = 1'b0;
				end else begin
					// Negative count repeats forever.
					if (!cur.repeats[15]) begin
						nxt.repeats = cur.repeats - 16'd1;
					end
					nxt.delay = cur.period;
				end
			end
		end
	end

endmodule

[tb/sv/periodic_ticker_bank_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for periodic_ticker_bank: random and directed arm/tick
// transactions against a bank of timers mirrored in the bench. Uses ptb_pkg.
module periodic_ticker_bank_tb;

	localparam int SLOTS      = ptb_pkg::SlotsDefault;
	// Items still queued below which neither side idles any more.
	localparam int TAIL_ITEMS = 40;
	localparam int HOLD_AFTER = 120;   // transactions accepted before the long hold-off
	localparam int HOLD_LEN   = 400;   // cycles the receiver refuses firings
	localparam int LINGER     = 3 * SLOTS + 10;
	localparam int RANDOM_ITEMS = 286;
	localparam int ITEM_W     = $bits(ptb_pkg::item_t);

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	ptb_pkg::item_t item = '0;
	logic           fire_valid;
	logic           fire_stall = 1'b0;
	ptb_pkg::fire_t fire;

	// Mirror of the timer bank, updated on every accepted transaction.
	logic               timer_on     [SLOTS];
	logic [15:0]        timer_delay  [SLOTS];
	logic [15:0]        timer_period [SLOTS];
	logic signed [15:0] timer_count  [SLOTS];
	logic [7:0]         timer_tag    [SLOTS];

	ptb_pkg::item_t item_backlog[$];   // transactions waiting to be offered
	ptb_pkg::fire_t firings_due[$];    // firings predicted but not yet seen

	int items_taken = 0;
	int arm_total = 0;
	int tick_total = 0;
	int firing_total = 0;
	int busiest_tick = 0;
	int fault_count = 0;

	int send_gap = 0;
	int send_run = 0;
	int stall_gap = 0;
	int stall_run = 0;

	logic long_hold = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	periodic_ticker_bank #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.fire_valid(fire_valid),
		.fire_stall(fire_stall),
		.fire      (fire)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted transaction to the mirrored bank and queue the firings
	// it causes. An arm rewrites the whole slot; a tick walks slots in order.
	function automatic void advance_timer_bank(ptb_pkg::item_t it);
		int             i;
		int             last_slot;
		int             fired;
		ptb_pkg::fire_t f;
		if (it.operation == ptb_pkg::OP_ARM) begin
			timer_on[it.slot]     = 1'b1;
			timer_delay[it.slot]  = it.first_delay;
			timer_period[it.slot] = it.reload_period;
			timer_count[it.slot]  = it.repeats;
			timer_tag[it.slot]    = it.payload_tag;
			arm_total++;
		end else begin
			tick_total++;
			// Each slot's update only touches itself, so the final firing is
			// known up front: the highest active slot sitting at zero delay.
			last_slot = -1;
			for (i = 0; i < SLOTS; i++)
				if (timer_on[i] && timer_delay[i] == 16'd0)
					last_slot = i;
			fired = 0;
			for (i = 0; i < SLOTS; i++) begin
				if (timer_on[i]) begin
					if (timer_delay[i] != 16'd0) begin
						timer_delay[i] = timer_delay[i] - 16'd1;
					end else begin
						f.fired_slot = 4'(i);
						f.fired_tag  = timer_tag[i];
						f.last       = (i == last_slot);
						firings_due.push_back(f);
						fired++;
						if (timer_count[i] == 16'sd0) begin
							timer_on[i] = 1'b0;
						end else begin
							// negative count fires forever, positive counts down
							if (timer_count[i] > 16'sd0)
								timer_count[i] = timer_count[i] - 16'sd1;
							timer_delay[i] = timer_period[i];
						end
					end
				end
			end
			if (fired > busiest_tick)
				busiest_tick = fired;
		end
	endfunction

	function automatic ptb_pkg::item_t make_arm(int s, logic [15:0] dly, logic [15:0] per,
			logic signed [15:0] rep, logic [7:0] tag);
		ptb_pkg::item_t it;
		it.operation     = ptb_pkg::OP_ARM;
		it.slot          = 4'(s);
		it.first_delay   = dly;
		it.reload_period = per;
		it.repeats       = rep;
		it.payload_tag   = tag;
		return it;
	endfunction

	function automatic ptb_pkg::item_t make_tick(logic fill);
		ptb_pkg::item_t it;
		it = fill ? '1 : '0;
		it.operation = ptb_pkg::OP_TICK;
		return it;
	endfunction

	// Mostly short delays so slots fire often, now and then wide ones.
	function automatic logic [15:0] pick_ticks();
		int unsigned roll;
		logic [15:0] v;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			v = 16'($urandom_range(0, 6));
		else if (roll < 92)
			v = 16'($urandom_range(7, 40));
		else if (roll < 97)
			v = 16'($urandom);
		else
			v = 16'hFFFF;
		return v;
	endfunction

	function automatic ptb_pkg::item_t random_item();
		ptb_pkg::item_t it;
		int unsigned    roll;
		// Start from noise: a tick ignores everything but the operation.
		it = ITEM_W'({$urandom, $urandom});
		it.operation = ($urandom_range(0, 99) < 40) ? ptb_pkg::OP_ARM : ptb_pkg::OP_TICK;
		if (it.operation == ptb_pkg::OP_ARM) begin
			it.first_delay   = pick_ticks();
			it.reload_period = pick_ticks();
			roll = $urandom_range(0, 99);
			if (roll < 20)
				it.repeats = -16'sd1;
			else if (roll < 25)
				it.repeats = 16'h8000 | 16'($urandom);
			else if (roll < 75)
				it.repeats = 16'($urandom_range(0, 4));
			else
				it.repeats = 16'($urandom_range(0, 32767));
		end
		return it;
	endfunction

	// Driver: offer the backlog, hold a stalled transaction unchanged, and
	// idle in random bursts except during the long hold-off and the tail.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				advance_timer_bank(item);
				items_taken++;
			end
			if (!(item_valid && item_stall)) begin
				if (send_gap > 0) begin
					item_valid <= 1'b0;
					send_gap--;
				end else if (item_backlog.size() == 0) begin
					item_valid <= 1'b0;
				end else begin
					item       <= item_backlog.pop_front();
					item_valid <= 1'b1;
					if (send_run > 0) begin
						send_run--;
					end else if (item_backlog.size() >= TAIL_ITEMS && !long_hold) begin
						send_gap = $urandom_range(1, 14);
						send_run = $urandom_range(0, 30);
					end
				end
			end
		end
	end

	// Long hold-off: once, refuse firings until hold_left runs out, so the
	// ring backs up and the block stalls its item channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && items_taken >= HOLD_AFTER) begin
				long_hold <= 1'b1;
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
			end else if (long_hold) begin
				if (hold_left == 1)
					long_hold <= 1'b0;
				hold_left <= hold_left - 1;
			end
		end
	end

	// Monitor: check each accepted firing against the oldest prediction, then
	// pick the next stall value.
	always @(posedge clk) begin
		ptb_pkg::fire_t want;
		if (arst_n) begin
			if (fire_valid && !fire_stall) begin
				if (firings_due.size() == 0) begin
					$error("firing with nothing pending: fired_slot %0d fired_tag 0x%02h",
						fire.fired_slot, fire.fired_tag);
					fault_count++;
				end else begin
					want = firings_due.pop_front();
					firing_total++;
					if (fire.fired_slot !== want.fired_slot) begin
						$error("fired_slot: expected %0d, actual %0d",
							want.fired_slot, fire.fired_slot);
						fault_count++;
					end
					if (fire.fired_tag !== want.fired_tag) begin
						$error("fired_tag: expected 0x%02h, actual 0x%02h",
							want.fired_tag, fire.fired_tag);
						fault_count++;
					end
					if (fire.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, fire.last);
						fault_count++;
					end
				end
			end
			if (long_hold) begin
				fire_stall <= 1'b1;
			end else if (item_backlog.size() < TAIL_ITEMS) begin
				fire_stall <= 1'b0;
			end else if (stall_gap > 0) begin
				fire_stall <= 1'b1;
				stall_gap--;
			end else if (stall_run > 0) begin
				fire_stall <= 1'b0;
				stall_run--;
			end else begin
				fire_stall <= 1'b0;
				stall_gap = $urandom_range(1, 14);
				stall_run = $urandom_range(0, 40);
			end
		end
	end

	initial begin
		int s;
		int drain;
		logic signed [15:0] rep;

		for (s = 0; s < SLOTS; s++)
			timer_on[s] = 1'b0;

		// Directed part: empty tick, one-shot at zero delay, widest values,
		// overwrite of a live slot, every slot firing on one tick, counts that
		// run out, positive and negative repeat counts.
		item_backlog.push_back(make_tick(1'b1));
		item_backlog.push_back(make_arm(0, 16'd0, 16'd0, 16'sd0, 8'h00));
		item_backlog.push_back(make_arm(SLOTS - 1, 16'hFFFF, 16'hFFFF, 16'sd32767, 8'hFF));
		item_backlog.push_back(make_tick(1'b0));
		item_backlog.push_back(make_tick(1'b1));
		for (s = 0; s < SLOTS; s++) begin
			case (s)
				3:       rep = -16'sd1;
				5:       rep = 16'sd2;
				9:       rep = -16'sd32768;
				default: rep = 16'sd0;
			endcase
			item_backlog.push_back(make_arm(s, 16'd0, 16'(s % 3), rep, 8'(s * 17)));
		end
		item_backlog.push_back(make_tick(1'b0));
		item_backlog.push_back(make_tick(1'b1));
		item_backlog.push_back(make_tick(1'b0));

		repeat (RANDOM_ITEMS)
			item_backlog.push_back(random_item());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every transaction to go in, then for the firings to drain.
		while (item_backlog.size() != 0 || item_valid)
			@(posedge clk);
		for (drain = 0; firings_due.size() != 0 && drain < 20000; drain++)
			@(posedge clk);
		// Give the walk time to show any firing nobody asked for.
		repeat (LINGER) @(posedge clk);
		if (firings_due.size() != 0) begin
			$error("%0d predicted firings never arrived", firings_due.size());
			fault_count++;
		end

		$display("Covered %0d arm and %0d tick transactions, %0d firings checked,",
			arm_total, tick_total, firing_total);
		$display("up to %0d firings in one tick, with one %0d-cycle receiver hold-off.",
			busiest_tick, HOLD_LEN);
		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[periodic_ticker_bank.f]
+incdir+design
design/ptb_pkg.sv
design/ptb_cell.sv
design/ptb_fire.sv
design/periodic_ticker_bank.sv
tb/sv/periodic_ticker_bank_tb.sv
